// ===== rtl/core/rbst_pkg.sv =====
// Package with shared widths and register indexes of the ray box slab test.
`default_nettype none
package rbst_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned PARAM_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5,
    CFG_SPEED_THR = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== rtl/core/rbst_div.sv =====
// Pipelined signed divider that forms (diff * 2^FRAC_BITS) / den, truncated toward zero.
`default_nettype none
module rbst_div import rbst_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic signed [DIFF_W-1:0]        diff_i,
  input  logic signed [COORD_W-1:0]       den_i,
  output logic signed [DIFF_W+FRAC_BITS:0] quo_o
);

  localparam int unsigned NW = DIFF_W + FRAC_BITS;
  localparam int unsigned DW = COORD_W;

  logic [NW-1:0] num_q [NW+1];
  logic [NW-1:0] quo_q [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [DW-1:0] den_q [NW+1];
  logic          neg_q [NW+1];
  logic signed [NW:0] res_q;

  logic [DIFF_W-1:0] num_mag;
  logic [DW-1:0]     den_mag;

  assign num_mag = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
  assign den_mag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  always_ff @(posedge clk_i) begin
    num_q[0] <= {num_mag, {FRAC_BITS{1'b0}}};
    quo_q[0] <= '0;
    rem_q[0] <= '0;
    den_q[0] <= den_mag;
    neg_q[0] <= diff_i[DIFF_W-1] ^ den_i[DW-1];
  end

  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_q[i-1], num_q[i-1][NW-1]};
    assign diff  = trial - {1'b0, den_q[i-1]};
    assign ge    = trial >= {1'b0, den_q[i-1]};

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q[i] <= {num_q[i-1][NW-2:0], 1'b0};
      quo_q[i] <= {quo_q[i-1][NW-2:0], ge};
      den_q[i] <= den_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= neg_q[NW] ? -$signed({1'b0, quo_q[NW]}) : $signed({1'b0, quo_q[NW]});
  end

  assign quo_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/ray_box_slab_test_core.sv =====
// Top level of the ray against axis-aligned box slab test pipeline.
`default_nettype none
// One ray item is taken in every clock cycle; busy is always low and the
// result comes out as a one-cycle strobe on result_valid_o, in order, with
// hit_param_o in unsigned Q15.16 at FRAC_BITS = 16. The path runs through the
// input stage, six radix-2 divider pipelines, one quotient bit per stage over
// 33 + FRAC_BITS stages, and the ordering and selection stages. The receiver cannot
// stall, so results must be taken when strobed. Box registers are written through
// the always-ready cfg port; the user must write them while no ray is in flight (not enforced).
module ray_box_slab_test_core import rbst_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   origin_x_i,
  input  logic signed [COORD_W-1:0]   origin_y_i,
  input  logic signed [COORD_W-1:0]   origin_z_i,
  input  logic signed [COORD_W-1:0]   dir_x_i,
  input  logic signed [COORD_W-1:0]   dir_y_i,
  input  logic signed [COORD_W-1:0]   dir_z_i,
  input  logic                        limit_to_unit_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COORD_W-1:0]          cfg_data_i,
  output logic                        result_valid_o,
  output logic                        hit_o,
  output logic [PARAM_W-1:0]          hit_param_o
);

  localparam int unsigned NW      = DIFF_W + FRAC_BITS;
  localparam int unsigned QW      = NW + 1;
  localparam int unsigned DIV_LAT = NW + 2;

  localparam logic signed [QW-1:0] ONE =
    {{(QW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [QW-1:0] PMAX = {{(QW-PARAM_W){1'b0}}, {PARAM_W{1'b1}}};

  typedef struct packed {
    logic       valid;
    logic       in_box;
    logic       slowfail;
    logic [2:0] fast;
    logic       limit;
  } sb_t;

  logic signed [COORD_W-1:0] box_lo_q [3];
  logic signed [COORD_W-1:0] box_hi_q [3];
  logic [THR_W-1:0]          thr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_lo_q[i] <= '0;
        box_hi_q[i] <= '0;
      end
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BOX_MIN_X: box_lo_q[0] <= cfg_data_i;
        CFG_BOX_MIN_Y: box_lo_q[1] <= cfg_data_i;
        CFG_BOX_MIN_Z: box_lo_q[2] <= cfg_data_i;
        CFG_BOX_MAX_X: box_hi_q[0] <= cfg_data_i;
        CFG_BOX_MAX_Y: box_hi_q[1] <= cfg_data_i;
        CFG_BOX_MAX_Z: box_hi_q[2] <= cfg_data_i;
        CFG_SPEED_THR: thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: slab differences, containment and speed checks.
  logic signed [COORD_W-1:0] org [3];
  logic signed [COORD_W-1:0] vel [3];
  logic [2:0] in_slab;
  logic [2:0] fast;
  sb_t        s0_d;
  sb_t        s0_q;
  logic signed [DIFF_W-1:0] dhi_q [3];
  logic signed [DIFF_W-1:0] dlo_q [3];
  logic signed [COORD_W-1:0] vel_q [3];

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign vel[0] = dir_x_i;
  assign vel[1] = dir_y_i;
  assign vel[2] = dir_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_in
    logic [DIFF_W-1:0] mag;
    assign mag = vel[a][COORD_W-1] ? DIFF_W'(-$signed({vel[a][COORD_W-1], vel[a]}))
                                   : DIFF_W'($signed({vel[a][COORD_W-1], vel[a]}));
    assign in_slab[a] = (org[a] >= box_lo_q[a]) && (org[a] <= box_hi_q[a]);
    assign fast[a]    = mag > {{(DIFF_W-THR_W){1'b0}}, thr_q};

    always_ff @(posedge clk_i) begin
      dhi_q[a] <= DIFF_W'(box_hi_q[a]) - DIFF_W'(org[a]);
      dlo_q[a] <= DIFF_W'(box_lo_q[a]) - DIFF_W'(org[a]);
      vel_q[a] <= vel[a];
    end
  end

  always_comb begin
    s0_d.valid    = start;
    s0_d.in_box   = &in_slab;
    s0_d.slowfail = |(~fast & ~in_slab);
    s0_d.fast     = fast;
    s0_d.limit    = limit_to_unit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else begin
      s0_q <= s0_d;
    end
  end

  // Slab time dividers, two per axis.
  logic signed [QW-1:0] ta [3];
  logic signed [QW-1:0] tb [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i  (clk_i),
      .diff_i (dhi_q[a]),
      .den_i  (vel_q[a]),
      .quo_o  (ta[a])
    );
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i  (clk_i),
      .diff_i (dlo_q[a]),
      .den_i  (vel_q[a]),
      .quo_o  (tb[a])
    );
  end

  sb_t sb_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) sb_q[i] <= '0;
    end else begin
      sb_q[0] <= s0_q;
      for (int i = 1; i < DIV_LAT; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // Per-axis ordering; a slow axis gives a lower bound of zero and no upper bound.
  sb_t p1_q, p2_q, p3_q, p4_q;
  logic signed [QW-1:0] lo_ax_q [3];
  logic signed [QW-1:0] hi_ax_q [3];
  logic [2:0]           hinf_ax_q;

  for (genvar a = 0; a < 3; a++) begin : g_ord
    always_ff @(posedge clk_i) begin
      if (sb_q[DIV_LAT-1].fast[a]) begin
        lo_ax_q[a] <= (ta[a] < tb[a]) ? ta[a] : tb[a];
      end else begin
        lo_ax_q[a] <= '0;
      end
      hi_ax_q[a]   <= (ta[a] < tb[a]) ? tb[a] : ta[a];
      hinf_ax_q[a] <= !sb_q[DIV_LAT-1].fast[a];
    end
  end

  logic signed [QW-1:0] lo01_q, lo2_q, hi01_q, hi2_q;
  logic                 hinf01_q, hinf2_q;

  always_ff @(posedge clk_i) begin
    lo01_q <= (lo_ax_q[0] > lo_ax_q[1]) ? lo_ax_q[0] : lo_ax_q[1];
    lo2_q  <= (lo_ax_q[2] > 0) ? lo_ax_q[2] : '0;
    if (hinf_ax_q[0]) begin
      hi01_q <= hi_ax_q[1];
    end else if (hinf_ax_q[1]) begin
      hi01_q <= hi_ax_q[0];
    end else begin
      hi01_q <= (hi_ax_q[0] < hi_ax_q[1]) ? hi_ax_q[0] : hi_ax_q[1];
    end
    hinf01_q <= hinf_ax_q[0] & hinf_ax_q[1];
    hi2_q    <= hi_ax_q[2];
    hinf2_q  <= hinf_ax_q[2];
  end

  logic signed [QW-1:0] lo_q, hi_q;
  logic                 hinf_q;

  always_ff @(posedge clk_i) begin
    lo_q <= (lo01_q > lo2_q) ? lo01_q : lo2_q;
    if (hinf01_q) begin
      hi_q <= hi2_q;
    end else if (hinf2_q) begin
      hi_q <= hi01_q;
    end else begin
      hi_q <= (hi01_q < hi2_q) ? hi01_q : hi2_q;
    end
    hinf_q <= hinf01_q & hinf2_q;
  end

  logic signed [QW-1:0] t_q;
  logic                 ok_q, tinf_q;

  always_ff @(posedge clk_i) begin
    ok_q   <= !p3_q.slowfail && (hinf_q || ((lo_q <= hi_q) && (hi_q >= 0)));
    tinf_q <= !(lo_q > 0) && hinf_q;
    t_q    <= (lo_q > 0) ? lo_q : hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
      p4_q <= '0;
    end else begin
      p1_q <= sb_q[DIV_LAT-1];
      p2_q <= p1_q;
      p3_q <= p2_q;
      p4_q <= p3_q;
    end
  end

  // Range limit, saturation and result registers.
  logic                 over_one, sat, hit_d;
  logic                 rvalid_q, hit_q;
  logic [PARAM_W-1:0]   param_q;

  assign over_one = tinf_q || (t_q > ONE);
  assign sat      = tinf_q || (t_q > PMAX);
  assign hit_d    = p4_q.in_box || (ok_q && !(p4_q.limit && over_one));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= p4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    if (!p4_q.in_box && hit_d) begin
      param_q <= sat ? PMAX[PARAM_W-1:0] : t_q[PARAM_W-1:0];
    end else begin
      param_q <= '0;
    end
  end

  assign result_valid_o = rvalid_q;
  assign hit_o          = hit_q;
  assign hit_param_o    = param_q;

endmodule
`default_nettype wire

// ===== sim/ray_box_slab_test_core_tb.sv =====
// Self-checking testbench for the ray box slab test core with a scoreboard class.
`timescale 1ns / 100ps
module ray_box_slab_test_core_tb;
  import rbst_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 41;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic hit;
    logic [PARAM_W-1:0] param;
  } hit_t;

  class hit_scoreboard;
    hit_t pending[$];
    int errors;

    function void note_ray(hit_t h);
      pending.push_back(h);
    endfunction

    function void check_hit(logic hit, logic [PARAM_W-1:0] param);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d param=%h", $time, hit, param);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.hit !== hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, hit);
        errors++;
      end
      if (e.param !== param) begin
        $display("%0t: hit_param expected %h actual %h", $time, e.param, param);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [COORD_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic limit_to_unit_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic hit_o;
  logic [PARAM_W-1:0] hit_param_o;

  longint box_lo[3];
  longint box_hi[3];
  longint speed_thr;
  longint cycles;
  hit_scoreboard sb;
  bit no_idle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ray_box_slab_test_core #(.FRAC_BITS(FRAC)) u_top (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (result_valid_o) sb.check_hit(hit_o, hit_param_o);
  end

  function automatic bit narrow_slab(longint org, longint vel, int ax,
                                     ref longint lo, ref longint hi);
    longint mag, ta, tb, s;
    mag = vel < 0 ? -vel : vel;
    if (mag > speed_thr) begin
      ta = ((box_hi[ax] - org) * (longint'(1) << FRAC)) / vel;
      tb = ((box_lo[ax] - org) * (longint'(1) << FRAC)) / vel;
      if (ta > tb) begin
        s = ta; ta = tb; tb = s;
      end
      if (ta > lo) lo = ta;
      if (tb < hi) hi = tb;
      return !(lo > hi || hi < 0);
    end
    return org >= box_lo[ax] && org <= box_hi[ax];
  endfunction

  function automatic hit_t predict_hit(longint org[3], longint vel[3], bit lim);
    hit_t r;
    longint lo, hi, t;
    bit in_box;
    r.hit = 1'b0;
    r.param = '0;
    lo = 0;
    hi = 64'h7FFF_FFFF_FFFF_FFFF;
    in_box = 1;
    for (int i = 0; i < 3; i++)
      if (org[i] < box_lo[i] || org[i] > box_hi[i]) in_box = 0;
    if (in_box) begin
      r.hit = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      if (!narrow_slab(org[i], vel[i], i, lo, hi)) return r;
    t = lo > 0 ? lo : hi;
    if (t < 0 || (lim && t > (longint'(1) << FRAC))) return r;
    if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
    r.hit = 1'b1;
    r.param = t[PARAM_W-1:0];
    return r;
  endfunction

  task automatic idle_gap();
    if (!no_idle) while ($urandom_range(99) < 34) @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [COORD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (idx <= CFG_BOX_MIN_Z) box_lo[idx] = longint'(signed'(val));
    else if (idx <= CFG_BOX_MAX_Z) box_hi[idx - CFG_BOX_MAX_X] = longint'(signed'(val));
    else speed_thr = val[THR_W-1:0];
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz, logic [15:0] thr);
    write_reg(CFG_BOX_MIN_X, lx);
    write_reg(CFG_BOX_MIN_Y, ly);
    write_reg(CFG_BOX_MIN_Z, lz);
    write_reg(CFG_BOX_MAX_X, hx);
    write_reg(CFG_BOX_MAX_Y, hy);
    write_reg(CFG_BOX_MAX_Z, hz);
    write_reg(CFG_SPEED_THR, {16'd0, thr});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_ray(logic [31:0] ox, oy, oz, vx, vy, vz, bit lim);
    longint org[3], vel[3];
    origin_x_i <= ox; origin_y_i <= oy; origin_z_i <= oz;
    dir_x_i <= vx; dir_y_i <= vy; dir_z_i <= vz;
    limit_to_unit_i <= lim;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    org[0] = longint'(signed'(ox)); org[1] = longint'(signed'(oy));
    org[2] = longint'(signed'(oz));
    vel[0] = longint'(signed'(vx)); vel[1] = longint'(signed'(vy));
    vel[2] = longint'(signed'(vz));
    sb.note_ray(predict_hit(org, vel, lim));
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(negedge clk_i);
      idle_gap();
    end
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
      2: return $urandom_range(32'h0000_0400) - 32'h0000_0200;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic random_rays(int n);
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(9);
      send_ray(rand_coord(m < 7 ? 1 : (m == 9 ? 3 : 0)),
               rand_coord(m < 7 ? 1 : 0), rand_coord(m < 7 ? 1 : (m == 8 ? 3 : 0)),
               rand_coord(m < 5 ? 1 : (m < 7 ? 2 : 0)),
               rand_coord(m < 5 ? 1 : (m == 6 ? 3 : 2)),
               rand_coord(m < 6 ? 1 : 0), 1'($urandom_range(1)));
    end
    start <= 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    no_idle = 0;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = 0; box_hi[i] = 0;
    end
    speed_thr = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rays against a box from -1.0 to +1.0 on each axis.
    set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
            32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0100);
    send_ray(0, 0, 0, 0, 0, 0, 1);
    send_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0, 1);
    send_ray(32'hFFFD_0000, 0, 0, 32'h0004_0000, 0, 0, 1);
    send_ray(32'hFFFD_0000, 0, 0, 32'h0001_0000, 0, 0, 1);
    send_ray(32'hFFFD_0000, 0, 0, 32'h0001_0000, 0, 0, 0);
    send_ray(32'h0003_0000, 0, 0, 32'h0001_0000, 0, 0, 0);
    send_ray(32'hFFFD_0000, 32'h0003_0000, 0, 32'h0001_0000, 32'h0000_0080, 0, 0);
    send_ray(32'hFFFD_0000, 32'h0003_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_ray(32'h8000_0000, 0, 0, 32'h0000_0101, 0, 0, 0);
    send_ray(32'h8000_0000, 0, 0, 32'h0000_0100, 0, 0, 0);
    send_ray(32'hFFFD_0000, 32'h0000_8000, 32'hFFFF_8000,
             32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000, 0);
    start <= 1'b0;
    drain();

    // Zero threshold, inverted box on x.
    set_box(32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
            32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
    send_ray(0, 0, 0, 32'h0000_0001, 0, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0, 0);
    send_ray(32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    start <= 1'b0;
    drain();

    set_box(32'hFFFE_0000, 32'hFFFF_8000, 32'hFFFF_0000,
            32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 16'h0040);
    random_rays(600);
    drain();

    no_idle = 1;
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    random_rays(150);
    drain();
    no_idle = 0;

    set_box(32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_C000,
            32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 16'hFFFF);
    random_rays(400);
    drain();

    set_box(32'h0000_0000, 32'hFFFF_0000, 32'hFFFD_0000,
            32'h0002_8000, 32'h0001_0000, 32'h0000_0000, 16'h0008);
    random_rays(650);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/rbst_pkg.sv
rtl/core/rbst_div.sv
rtl/core/ray_box_slab_test_core.sv
sim/ray_box_slab_test_core_tb.sv
